[rtl/frg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frg_pkg: shared types and constants of the fraction reducer
// Word layouts of the request and response channels, the control structs
// between the sequencer and the shared divider, and the magnitude helper.
// ----------------------------------------------------------------------------
package frg_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

   // largest positive value of a signed word, also the saturation limit
   localparam logic [DATA_WIDTH-1:0] HALF_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] numerator_in;
      logic signed [DATA_WIDTH-1:0] denominator_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] numerator_out;
      logic [DATA_WIDTH-2:0]        denominator_out;
      logic                         zero_denominator;
   } rsp_type;

   // operands handed to the divider with a start pulse
   typedef struct packed {
      logic                  start;
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } div_req_type;

   // quotient and remainder, valid while done is high
   typedef struct packed {
      logic                  done;
      logic [DATA_WIDTH-1:0] quotient;
      logic [DATA_WIDTH-1:0] remainder;
   } div_rsp_type;

   // unsigned magnitude of a two's complement word; the most negative
   // value maps to 2^(DATA_WIDTH-1) exactly
   function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
      magnitude = v[DATA_WIDTH-1] ? (~v + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : v;
   endfunction

endpackage

[rtl/frg_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frg_divider: restoring unsigned divider, one quotient bit per cycle
// Latches dividend and divisor on start, runs DATA_WIDTH steps and pulses
// done for one cycle with quotient and remainder. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module frg_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  frg_pkg::div_req_type div_req,
   output frg_pkg::div_rsp_type div_rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [frg_pkg::CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [frg_pkg::DATA_WIDTH-1:0]  rem_ff, rem_in;
   logic [frg_pkg::DATA_WIDTH-1:0]  quo_ff, quo_in;
   logic [frg_pkg::DATA_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [frg_pkg::DATA_WIDTH:0]    shifted;
   logic [frg_pkg::DATA_WIDTH:0]    diff;

   // trial subtract of the divisor from the shifted partial remainder
   assign shifted = {rem_ff, quo_ff[frg_pkg::DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         // keep the difference when it did not borrow
         if (!diff[frg_pkg::DATA_WIDTH]) begin
            rem_in = diff[frg_pkg::DATA_WIDTH-1:0];
            quo_in = {quo_ff[frg_pkg::DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[frg_pkg::DATA_WIDTH-1:0];
            quo_in = {quo_ff[frg_pkg::DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == frg_pkg::CNT_WIDTH'(frg_pkg::DATA_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         // load operands, dividend shifts out of the quotient register
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[rtl/fraction_reduce_gcd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reduce_gcd: reduce a signed fraction to lowest terms
// Euclid's remainder algorithm on the magnitudes, then both parts divided by
// the common divisor, sign moved to the numerator.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Every request
// gives exactly one response word, shown on rsp_data for a single cycle while
// rsp_strobe is high; the receiver cannot stall it and must take it then.
// All divisions run on one shared restoring divider at one quotient bit per
// cycle. A request runs its Euclid remainder steps, at most 45 for 32-bit
// magnitudes and often far fewer, then the numerator and the denominator
// divisions, and then raises rsp_strobe; busy is already low during that
// response cycle, so the next request can be taken in that same cycle. A zero
// denominator is answered in the cycle after the request is taken, with 0/1
// and the error flag set.
// Positive results of magnitude 2^(DATA_WIDTH-1) saturate to the largest
// positive value.
// ----------------------------------------------------------------------------
module fraction_reduce_gcd (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  frg_pkg::req_type req_data,
   output logic             rsp_strobe,
   output frg_pkg::rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GCD  = 3'd1;
   localparam logic [2:0] ST_NUM  = 3'd2;
   localparam logic [2:0] ST_DEN  = 3'd3;

   logic [2:0]                     state_ff, state_in;
   logic [frg_pkg::DATA_WIDTH-1:0] x_ff, x_in;
   logic [frg_pkg::DATA_WIDTH-1:0] y_ff, y_in;
   logic [frg_pkg::DATA_WIDTH-1:0] nmag_ff, nmag_in;
   logic [frg_pkg::DATA_WIDTH-1:0] dmag_ff, dmag_in;
   logic [frg_pkg::DATA_WIDTH-1:0] nq_ff, nq_in;
   logic                           sdiff_ff, sdiff_in;
   logic                           strobe_ff, strobe_in;
   frg_pkg::rsp_type               rsp_ff, rsp_in;
   frg_pkg::div_req_type           div_req;
   frg_pkg::div_rsp_type           div_rsp;
   logic [frg_pkg::DATA_WIDTH-1:0] req_nmag;
   logic [frg_pkg::DATA_WIDTH-1:0] req_dmag;
   logic [frg_pkg::DATA_WIDTH-1:0] dq;
   logic                           rneg;

   frg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_nmag = frg_pkg::magnitude(req_data.numerator_in);
   assign req_dmag = frg_pkg::magnitude(req_data.denominator_in);
   assign dq       = div_rsp.quotient;
   assign rneg     = (nq_ff != '0) && sdiff_ff;

   // sequencer: Euclid steps, then numerator and denominator divisions
   always_comb begin
      state_in         = state_ff;
      x_in             = x_ff;
      y_in             = y_ff;
      nmag_in          = nmag_ff;
      dmag_in          = dmag_ff;
      nq_in            = nq_ff;
      sdiff_in         = sdiff_ff;
      strobe_in        = 1'b0;
      rsp_in           = rsp_ff;
      div_req.start    = 1'b0;
      div_req.dividend = x_ff;
      div_req.divisor  = y_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sdiff_in = req_data.numerator_in[frg_pkg::DATA_WIDTH-1]
                        ^ req_data.denominator_in[frg_pkg::DATA_WIDTH-1];
               if (req_dmag == '0) begin
                  // answer 0/1 with the error flag, without starting the divider
                  strobe_in               = 1'b1;
                  rsp_in.numerator_out    = '0;
                  rsp_in.denominator_out  = (frg_pkg::DATA_WIDTH-1)'(1);
                  rsp_in.zero_denominator = 1'b1;
               end else begin
                  nmag_in          = req_nmag;
                  dmag_in          = req_dmag;
                  x_in             = req_nmag;
                  y_in             = req_dmag;
                  div_req.start    = 1'b1;
                  div_req.dividend = req_nmag;
                  div_req.divisor  = req_dmag;
                  state_in         = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (div_rsp.done) begin
               x_in = y_ff;
               y_in = div_rsp.remainder;
               div_req.start = 1'b1;
               if (div_rsp.remainder == '0) begin
                  // divisor found in y: divide the numerator by it
                  div_req.dividend = nmag_ff;
                  div_req.divisor  = y_ff;
                  state_in         = ST_NUM;
               end else begin
                  div_req.dividend = y_ff;
                  div_req.divisor  = div_rsp.remainder;
               end
            end
         end
         ST_NUM: begin
            if (div_rsp.done) begin
               nq_in            = div_rsp.quotient;
               div_req.start    = 1'b1;
               div_req.dividend = dmag_ff;
               div_req.divisor  = x_ff;
               state_in         = ST_DEN;
            end
         end
         ST_DEN: begin
            if (div_rsp.done) begin
               // apply sign and saturate both parts
               strobe_in               = 1'b1;
               rsp_in.zero_denominator = 1'b0;
               if (rneg) begin
                  rsp_in.numerator_out = ~nq_ff + {{(frg_pkg::DATA_WIDTH-1){1'b0}}, 1'b1};
               end else if (nq_ff > frg_pkg::HALF_MAX) begin
                  rsp_in.numerator_out = frg_pkg::HALF_MAX;
               end else begin
                  rsp_in.numerator_out = nq_ff;
               end
               if (dq > frg_pkg::HALF_MAX) begin
                  rsp_in.denominator_out = frg_pkg::HALF_MAX[frg_pkg::DATA_WIDTH-2:0];
               end else begin
                  rsp_in.denominator_out = dq[frg_pkg::DATA_WIDTH-2:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      nmag_ff  <= nmag_in;
      dmag_ff  <= dmag_in;
      nq_ff    <= nq_in;
      sdiff_ff <= sdiff_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fraction_reduce_gcd
// Drives signed fractions through the start/busy command port. A clocked
// monitor predicts each reduced fraction from the accepted word and checks
// every response word against the oldest prediction, field by field. Stimulus
// is a directed set of corner fractions, then random fractions drawn from
// several shapes: full-range, small, sharing a large common factor, zero
// parts, and extreme values.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_WORDS = 1880;
   localparam int SETTLE_CYCLES = 2000;

   typedef struct {
      frg_pkg::req_type word;
      bit               drain_first;
   } fraction_job_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   frg_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   frg_pkg::rsp_type rsp_data;

   fraction_job_type pending_fractions[$];
   frg_pkg::rsp_type reduced_q[$];
   logic             took_word = 1'b0;
   int               gap_left = 0;
   int               words_sent = 0;
   int               failures = 0;
   int               words_taken = 0;
   int               zero_den_seen = 0;
   int               negative_seen = 0;
   int               saturated_seen = 0;

   fraction_reduce_gcd DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // reduce a fraction: Euclid on the magnitudes, sign on the numerator,
   // saturate positive parts that reach 2^(DATA_WIDTH-1)
   function automatic frg_pkg::rsp_type lowest_terms(input frg_pkg::req_type f);
      logic [frg_pkg::DATA_WIDTH-1:0] num_mag, den_mag, a, b, r;
      logic                           num_neg, den_neg;
      frg_pkg::rsp_type               res;
      num_neg = f.numerator_in[frg_pkg::DATA_WIDTH-1];
      den_neg = f.denominator_in[frg_pkg::DATA_WIDTH-1];
      num_mag = f.numerator_in;
      den_mag = f.denominator_in;
      if (num_neg) num_mag = -num_mag;
      if (den_neg) den_mag = -den_mag;
      res = '0;
      if (den_mag == '0) begin
         res.denominator_out = (frg_pkg::DATA_WIDTH-1)'(1);
         res.zero_denominator = 1'b1;
         return res;
      end
      a = num_mag;
      b = den_mag;
      while (b != '0) begin
         r = a % b;
         a = b;
         b = r;
      end
      num_mag = num_mag / a;
      den_mag = den_mag / a;
      if (num_mag != '0 && num_neg != den_neg)
         res.numerator_out = -num_mag;
      else
         res.numerator_out = (num_mag > frg_pkg::HALF_MAX) ? frg_pkg::HALF_MAX : num_mag;
      res.denominator_out = (den_mag > frg_pkg::HALF_MAX)
                          ? frg_pkg::HALF_MAX[frg_pkg::DATA_WIDTH-2:0]
                          : den_mag[frg_pkg::DATA_WIDTH-2:0];
      return res;
   endfunction

   // idle cycles before the next word; some stretches run back to back
   function automatic int draw_gap(input int sent);
      if ((sent / 60) % 4 == 3) return 0;
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [frg_pkg::DATA_WIDTH-1:0] corner_value(input int idx);
      case (idx)
         0:       return '0;
         1:       return 1;
         2:       return '1;
         3:       return frg_pkg::HALF_MAX;
         4:       return ~frg_pkg::HALF_MAX;
         default: return ~frg_pkg::HALF_MAX + 1;
      endcase
   endfunction

   task automatic add_fraction(input logic [frg_pkg::DATA_WIDTH-1:0] num,
                               input logic [frg_pkg::DATA_WIDTH-1:0] den,
                               input bit drain);
      fraction_job_type job;
      job.word.numerator_in = num;
      job.word.denominator_in = den;
      job.drain_first = drain;
      pending_fractions.push_back(job);
   endtask

   // drive: hold a word until taken, then wait out the gap (and, for a drain job, all responses) and present the next
   always @(negedge clock) begin
      if (!reset && (!start || took_word)) begin
         if (gap_left != 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_fractions.size() != 0 &&
                      !(pending_fractions[0].drain_first && reduced_q.size() != 0)) begin
            req_data <= pending_fractions[0].word;
            start <= 1'b1;
            gap_left <= draw_gap(words_sent);
            words_sent <= words_sent + 1;
            pending_fractions.delete(0);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check the response word first, then record the accepted request
   always @(posedge clock) begin
      frg_pkg::rsp_type want;
      if (reset) begin
         took_word <= 1'b0;
      end else begin
         took_word <= start && !busy;
         if (rsp_strobe) begin
            if (reduced_q.size() == 0) begin
               $error("response word with no request outstanding");
               failures++;
            end else begin
               want = reduced_q.pop_front();
               if (rsp_data.numerator_out !== want.numerator_out) begin
                  $error("numerator_out: expected %0d, got %0d",
                         want.numerator_out, rsp_data.numerator_out);
                  failures++;
               end
               if (rsp_data.denominator_out !== want.denominator_out) begin
                  $error("denominator_out: expected %0d, got %0d",
                         want.denominator_out, rsp_data.denominator_out);
                  failures++;
               end
               if (rsp_data.zero_denominator !== want.zero_denominator) begin
                  $error("zero_denominator: expected %0b, got %0b",
                         want.zero_denominator, rsp_data.zero_denominator);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            want = lowest_terms(req_data);
            reduced_q.push_back(want);
            words_taken++;
            if (want.zero_denominator) zero_den_seen++;
            if (want.numerator_out[frg_pkg::DATA_WIDTH-1]) negative_seen++;
            if (want.numerator_out == frg_pkg::HALF_MAX ||
                want.denominator_out == frg_pkg::HALF_MAX[frg_pkg::DATA_WIDTH-2:0])
               saturated_seen++;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int pick;
      int factor;
      logic [frg_pkg::DATA_WIDTH-1:0] num, den;

      // directed corners
      add_fraction(0, 1, 1'b0);
      add_fraction(0, -5, 1'b0);
      add_fraction(0, 0, 1'b0);
      add_fraction(7, 0, 1'b0);
      add_fraction(-7, 0, 1'b0);
      add_fraction(frg_pkg::HALF_MAX, frg_pkg::HALF_MAX, 1'b0);
      add_fraction(-frg_pkg::HALF_MAX, frg_pkg::HALF_MAX, 1'b0);
      add_fraction(frg_pkg::HALF_MAX, -frg_pkg::HALF_MAX, 1'b0);
      add_fraction(~frg_pkg::HALF_MAX, 1, 1'b0);
      add_fraction(~frg_pkg::HALF_MAX, -1, 1'b0);
      add_fraction(~frg_pkg::HALF_MAX, -3, 1'b0);
      add_fraction(1, ~frg_pkg::HALF_MAX, 1'b0);
      add_fraction(-1, ~frg_pkg::HALF_MAX, 1'b0);
      add_fraction(~frg_pkg::HALF_MAX, ~frg_pkg::HALF_MAX, 1'b0);
      add_fraction(~frg_pkg::HALF_MAX, 0, 1'b0);
      add_fraction(6, -4, 1'b0);
      add_fraction(-12, -18, 1'b0);
      add_fraction(1, 1, 1'b0);
      add_fraction(-1, 1, 1'b0);
      add_fraction(100, 25, 1'b0);
      add_fraction(1836311903, 1134903170, 1'b0);
      add_fraction(-1134903170, 1836311903, 1'b0);
      add_fraction(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      add_fraction(2147483629, 2147483587, 1'b0);

      // random fractions of several shapes
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            num = $urandom();
            den = $urandom();
         end else if (pick < 60) begin
            num = $urandom_range(0, 2000) - 1000;
            den = $urandom_range(0, 2000) - 1000;
         end else if (pick < 83) begin
            factor = $urandom_range(1, 46340);
            num = factor * $urandom_range(0, 46340);
            den = factor * $urandom_range(1, 46340);
            if ($urandom_range(0, 1)) num = -num;
            if ($urandom_range(0, 1)) den = -den;
         end else if (pick < 91) begin
            num = $urandom();
            den = $urandom();
            if ($urandom_range(0, 1)) num = '0;
            else den = '0;
         end else begin
            num = $urandom_range(0, 1) ? corner_value($urandom_range(0, 5)) : $urandom();
            den = $urandom_range(0, 1) ? corner_value($urandom_range(0, 5)) : $urandom();
         end
         add_fraction(num, den, (i % 400) == 0);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain everything, then give stray responses time to show up
      while (pending_fractions.size() != 0 || start || reduced_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Reduced %0d fractions: %0d zero denominators, %0d negative, %0d saturated",
               words_taken, zero_den_seen, negative_seen, saturated_seen);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
